/* src/vrn_pkg.sv */
// shared types, widths and constants for the reflect and normalise block
package vrn_pkg;

    // fixed field widths
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int OUT_FRAC   = 14;
    localparam int PROJ_SHIFT = 22;

    // internal widths, sized for the input width above
    localparam int P_W    = 2 * IN_W;          // one incident by normal product
    localparam int D_W    = P_W + 2;           // dot product
    localparam int T_W    = D_W + IN_W;        // dot product times a normal component
    localparam int R_W    = IN_W + 12;         // reflected component
    localparam int S_W    = 2 * R_W;           // squared length
    localparam int ROOT_W = S_W / 2;           // integer square root
    localparam int MAG_W  = R_W - 1;           // magnitude of a reflected component
    localparam int NUM_W  = MAG_W + OUT_FRAC;  // dividend
    localparam int Q_W    = OUT_FRAC + 1;      // quotient magnitude

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic signed [IN_W-1:0] inc_x;
        logic signed [IN_W-1:0] inc_y;
        logic signed [IN_W-1:0] inc_z;
        logic signed [IN_W-1:0] nrm_x;
        logic signed [IN_W-1:0] nrm_y;
        logic signed [IN_W-1:0] nrm_z;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] refl_x;
        logic signed [OUT_W-1:0] refl_y;
        logic signed [OUT_W-1:0] refl_z;
        logic                    zero_length;
    } out_word_t;

    // reflected vector with its squared length, front to back
    typedef struct packed {
        logic signed [R_W-1:0] rx;
        logic signed [R_W-1:0] ry;
        logic signed [R_W-1:0] rz;
        logic [S_W-1:0]        s;
        logic                  zero;
    } refl_t;

    // reflected vector with its length, square root to divider
    typedef struct packed {
        logic signed [R_W-1:0] rx;
        logic signed [R_W-1:0] ry;
        logic signed [R_W-1:0] rz;
        logic [ROOT_W-1:0]     m;
        logic                  zero;
    } root_t;

endpackage

/* src/vrn_front.sv */
// front pipeline: dot product, reflection and squared length
module vrn_front import vrn_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_word_t item,
    input  logic     fifo_full,
    output logic     push,
    output refl_t    push_data
);

    logic [5:0] v_reg;
    logic       en;

    logic signed [IN_W-1:0] i1_reg [3];
    logic signed [IN_W-1:0] n1_reg [3];
    logic signed [P_W-1:0]  p1_reg [3];
    logic signed [IN_W-1:0] i2_reg [3];
    logic signed [IN_W-1:0] n2_reg [3];
    logic signed [D_W-1:0]  d2_reg;
    logic signed [IN_W-1:0] i3_reg [3];
    logic signed [R_W-1:0]  pj3_reg [3];
    logic signed [R_W-1:0]  r4_reg [3];
    logic signed [R_W-1:0]  r5_reg [3];
    logic [S_W-1:0]         sq5_reg [3];
    logic                   z5_reg;
    refl_t                  out6_reg;

    logic signed [T_W-1:0]  t_c [3];
    logic signed [S_W-1:0]  sq_c [3];

    // whole front stalls only when its last word cannot enter the queue
    assign en         = !(v_reg[5] && fifo_full);
    assign item_ready = en;
    assign push       = v_reg[5] && en;
    assign push_data  = out6_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], item_valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_c[k]  = d2_reg * n2_reg[k];
            sq_c[k] = r4_reg[k] * r4_reg[k];
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products of incident and normal
            i1_reg[0] <= item.inc_x;
            i1_reg[1] <= item.inc_y;
            i1_reg[2] <= item.inc_z;
            n1_reg[0] <= item.nrm_x;
            n1_reg[1] <= item.nrm_y;
            n1_reg[2] <= item.nrm_z;
            p1_reg[0] <= item.inc_x * item.nrm_x;
            p1_reg[1] <= item.inc_y * item.nrm_y;
            p1_reg[2] <= item.inc_z * item.nrm_z;
            // dot product
            d2_reg <= D_W'(p1_reg[0]) + D_W'(p1_reg[1]) + D_W'(p1_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                i2_reg[k] <= i1_reg[k];
                n2_reg[k] <= n1_reg[k];
                // projection 2*d*n, floor shift back to input format
                i3_reg[k]  <= i2_reg[k];
                pj3_reg[k] <= R_W'(t_c[k] >>> (PROJ_SHIFT - 1));
                // reflected component
                r4_reg[k]  <= R_W'(i3_reg[k]) - pj3_reg[k];
                // squares
                r5_reg[k]  <= r4_reg[k];
                sq5_reg[k] <= unsigned'(sq_c[k]);
            end
            z5_reg <= (r4_reg[0] == '0) && (r4_reg[1] == '0) && (r4_reg[2] == '0);
            // squared length
            out6_reg.rx   <= r5_reg[0];
            out6_reg.ry   <= r5_reg[1];
            out6_reg.rz   <= r5_reg[2];
            out6_reg.s    <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            out6_reg.zero <= z5_reg;
        end
    end

endmodule

/* src/vrn_fifo.sv */
// short queue of reflected words between front and back
module vrn_fifo import vrn_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  refl_t push_data,
    input  logic  pop,
    output refl_t pop_data,
    output logic  full,
    output logic  empty
);

    refl_t                mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/vrn_sqrt.sv */
// pipelined integer square root, one root bit per stage
module vrn_sqrt import vrn_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  refl_t in_data,
    output logic  out_valid,
    output root_t out_data
);

    localparam int REM_W = ROOT_W + 4;

    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
        logic [S_W-1:0]        sh;
        logic signed [R_W-1:0] rx;
        logic signed [R_W-1:0] ry;
        logic signed [R_W-1:0] rz;
        logic                  zero;
    } sq_stage_t;

    sq_stage_t         st_reg [ROOT_W];
    logic [ROOT_W-1:0] v_reg;
    sq_stage_t         init_c;

    // one restoring step: bring in two radicand bits, try the next root bit
    function automatic sq_stage_t sq_step(input sq_stage_t a);
        sq_stage_t        b;
        logic [REM_W-1:0] rn;
        logic [REM_W-1:0] trial;
        begin
            b     = a;
            rn    = {a.rem[REM_W-3:0], a.sh[S_W-1 -: 2]};
            trial = {2'b00, a.root, 2'b01};
            b.sh  = {a.sh[S_W-3:0], 2'b00};
            if (rn >= trial)
            begin
                b.rem  = rn - trial;
                b.root = {a.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                b.rem  = rn;
                b.root = {a.root[ROOT_W-2:0], 1'b0};
            end
            return b;
        end
    endfunction

    always_comb
    begin
        init_c.rem  = '0;
        init_c.root = '0;
        init_c.sh   = in_data.s;
        init_c.rx   = in_data.rx;
        init_c.ry   = in_data.ry;
        init_c.rz   = in_data.rz;
        init_c.zero = in_data.zero;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
        end
    end

    // root stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sq_step(init_c);
            for (int k = 1; k < ROOT_W; k++)
            begin
                st_reg[k] <= sq_step(st_reg[k-1]);
            end
        end
    end

    assign out_valid     = v_reg[ROOT_W-1];
    assign out_data.rx   = st_reg[ROOT_W-1].rx;
    assign out_data.ry   = st_reg[ROOT_W-1].ry;
    assign out_data.rz   = st_reg[ROOT_W-1].rz;
    assign out_data.m    = st_reg[ROOT_W-1].root;
    assign out_data.zero = st_reg[ROOT_W-1].zero;

endmodule

/* src/vrn_div.sv */
// three pipelined dividers, one quotient bit per stage, and the result register
module vrn_div import vrn_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  root_t     in_data,
    output logic      en,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

    typedef struct packed {
        logic [ROOT_W-1:0] pr;
        logic [Q_W-1:0]    lo;
        logic [Q_W-1:0]    q;
        logic              neg;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]       ln;
        logic [ROOT_W-1:0] m;
        logic              zero;
    } dv_stage_t;

    dv_stage_t      st_reg [Q_W];
    logic [Q_W-1:0] v_reg;
    dv_stage_t      init_c;
    out_word_t      res_reg;
    logic           res_valid_reg;
    logic signed [OUT_W-1:0] qs_c [3];

    // set up one lane: magnitude shifted into the output format
    function automatic lane_t lane_init(input logic signed [R_W-1:0] r);
        lane_t             l;
        logic [R_W-1:0]    mag;
        logic [NUM_W-1:0]  num;
        begin
            mag   = r[R_W-1] ? R_W'(-r) : R_W'(r);
            num   = {mag[MAG_W-1:0], {OUT_FRAC{1'b0}}};
            l.pr  = ROOT_W'(num >> Q_W);
            l.lo  = num[Q_W-1:0];
            l.q   = '0;
            l.neg = r[R_W-1];
            return l;
        end
    endfunction

    // one restoring division step
    function automatic lane_t lane_step(input lane_t a, input logic [ROOT_W-1:0] m);
        lane_t           b;
        logic [ROOT_W:0] t;
        logic            ge;
        begin
            b    = a;
            t    = {a.pr, a.lo[Q_W-1]};
            ge   = (t >= {1'b0, m});
            b.pr = ge ? ROOT_W'(t - {1'b0, m}) : ROOT_W'(t);
            b.lo = {a.lo[Q_W-2:0], 1'b0};
            b.q  = {a.q[Q_W-2:0], ge};
            return b;
        end
    endfunction

    function automatic dv_stage_t dv_step(input dv_stage_t a);
        dv_stage_t b;
        begin
            b = a;
            for (int j = 0; j < 3; j++)
            begin
                b.ln[j] = lane_step(a.ln[j], a.m);
            end
            return b;
        end
    endfunction

    // back end advances unless a finished result is held
    assign en = !res_valid_reg || result_ready;

    always_comb
    begin
        init_c.ln[0] = lane_init(in_data.rx);
        init_c.ln[1] = lane_init(in_data.ry);
        init_c.ln[2] = lane_init(in_data.rz);
        init_c.m     = in_data.m;
        init_c.zero  = in_data.zero;
    end

    // signed quotients, forced to zero for a zero-length vector
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            qs_c[j] = OUT_W'(st_reg[Q_W-1].ln[j].q);
            if (st_reg[Q_W-1].ln[j].neg)
            begin
                qs_c[j] = -qs_c[j];
            end
            if (st_reg[Q_W-1].zero)
            begin
                qs_c[j] = '0;
            end
        end
    end

    // stage valids and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[Q_W-2:0], in_valid};
            res_valid_reg <= v_reg[Q_W-1];
        end
    end

    // divider stages and result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= dv_step(init_c);
            for (int k = 1; k < Q_W; k++)
            begin
                st_reg[k] <= dv_step(st_reg[k-1]);
            end
            res_reg.refl_x      <= qs_c[0];
            res_reg.refl_y      <= qs_c[1];
            res_reg.refl_z      <= qs_c[2];
            res_reg.zero_length <= st_reg[Q_W-1].zero;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

/* src/vector_reflect_normalize_core.sv */
// top level of the reflect and normalise block
//
// Reflects an incident vector about a surface normal (three signed Q4.11
// components each) and scales the reflection to unit length in Q1.14.
// Input word: item_valid / item_ready / item. Result word:
// result_valid / result_ready / result. A word moves when valid and ready
// are both high at a rising edge.
// From input acceptance to result valid a word passes 6 front stages, the
// queue, 28 square root stages (one root bit each), 15 divider stages
// (one quotient bit each) and the result register.
// Throughput is one word per cycle while the receiver takes results.
// A zero-length reflection gives zero components with zero_length set.
// Reset (rst_n low, asynchronous) empties every stage and the queue; no
// clearing pass is needed afterwards.
// When the receiver stalls the back end holds; the front keeps accepting
// until the four-word queue is full and the last front stage holds a word,
// then item_ready drops.
module vector_reflect_normalize_core import vrn_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

    logic  push;
    refl_t push_data;
    logic  fifo_full;
    logic  fifo_empty;
    refl_t pop_data;
    logic  back_en;
    logic  pop;
    logic  root_valid;
    root_t root_data;

    assign pop = back_en && !fifo_empty;

    // front: reflection and squared length
    vrn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_data  (push_data)
    );

    // queue between the two halves
    vrn_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    // back: length
    vrn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (!fifo_empty),
        .in_data   (pop_data),
        .out_valid (root_valid),
        .out_data  (root_data)
    );

    // back: normalisation and result register
    vrn_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (root_valid),
        .in_data      (root_data),
        .en           (back_en),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* src/vrn_checker.sv */
// port-level checks for the reflect and normalise block
module vrn_checker import vrn_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input in_word_t  item,
    input logic      result_valid,
    input logic      result_ready,
    input out_word_t result
);

    // a waiting input word stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("input word changed while waiting");

    // a stalled result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // zero length gives zero components
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_length |->
            result.refl_x == '0 && result.refl_y == '0 && result.refl_z == '0)
        else $error("zero-length result with nonzero components");

    // unit scale bounds each component
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.refl_x >= -16'sd16384 && result.refl_x <= 16'sd16384 &&
            result.refl_y >= -16'sd16384 && result.refl_y <= 16'sd16384 &&
            result.refl_z >= -16'sd16384 && result.refl_z <= 16'sd16384)
        else $error("result component beyond unit scale");

    // a normalised word has a nonzero component
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.zero_length |->
            result.refl_x != '0 || result.refl_y != '0 || result.refl_z != '0)
        else $error("normalised result is all zero");

endmodule

bind vector_reflect_normalize_core vrn_checker u_vrn_checker (.*);

/* bench/tb_vector_reflect_normalize_core.sv */
// testbench for the reflect and normalise block: directed and random words against a predictor
`timescale 1ns / 1ps

module tb_vector_reflect_normalize_core;
    import vrn_pkg::*;

    localparam int LATENCY     = 51;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_word_t  item;
    logic      result_valid;
    logic      result_ready;
    out_word_t result;

    out_word_t expected_refl[$];
    int        mismatches;
    longint    cycle_count;
    int        burst_left;
    bit        stall_enable;

    vector_reflect_normalize_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor square root by bisection on a 64-bit value
    function automatic longint floor_root(longint sq);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= sq)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // reflect about the normal and scale to unit length
    function automatic out_word_t reflect_unit(in_word_t w);
        out_word_t o;
        longint    iv[3];
        longint    nv[3];
        longint    rv[3];
        longint    dot;
        longint    prod;
        longint    sq;
        longint    mag;
        longint    q;
        iv[0] = w.inc_x; iv[1] = w.inc_y; iv[2] = w.inc_z;
        nv[0] = w.nrm_x; nv[1] = w.nrm_y; nv[2] = w.nrm_z;
        dot = 0;
        for (int k = 0; k < 3; k++)
            dot += iv[k] * nv[k];
        sq = 0;
        for (int k = 0; k < 3; k++)
        begin
            prod  = 2 * dot * nv[k];
            rv[k] = iv[k] - (prod >>> PROJ_SHIFT);
            sq   += rv[k] * rv[k];
        end
        o = '0;
        if (sq == 0)
        begin
            o.zero_length = 1'b1;
            return o;
        end
        mag = floor_root(sq);
        for (int k = 0; k < 3; k++)
        begin
            q = (rv[k] * (64'sd1 << OUT_FRAC)) / mag;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            if (k == 0) o.refl_x = q[15:0];
            else if (k == 1) o.refl_y = q[15:0];
            else o.refl_z = q[15:0];
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // send one word, with burst and gap pacing; valid drops only in a gap
    task automatic send_word(in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 12)) : 0;
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= w;
        expected_refl.push_back(reflect_unit(w));
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_refl.size() != 0)
            @(posedge clk);
    endtask

    function automatic in_word_t make_word(int ix, int iy, int iz, int nx, int ny, int nz);
        in_word_t w;
        w.inc_x = 16'(ix); w.inc_y = 16'(iy); w.inc_z = 16'(iz);
        w.nrm_x = 16'(nx); w.nrm_y = 16'(ny); w.nrm_z = 16'(nz);
        return w;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 4096)) - 2048);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // extremes, zero length and axis cases
    task automatic test_directed();
        send_word(make_word(0, 0, 0, 0, 0, 0));
        send_word(make_word(0, 0, 0, 2048, 0, 0));
        send_word(make_word(2048, 0, 0, 2048, 0, 0));
        send_word(make_word(2048, 0, 0, 0, 0, 0));
        send_word(make_word(0, -2048, 0, 0, 2048, 0));
        send_word(make_word(0, 0, 2048, 0, 0, 2048));
        send_word(make_word(1448, -1448, 0, 0, 2048, 0));
        send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768));
        send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767));
        send_word(make_word(-32768, 32767, -32768, 32767, -32768, 32767));
        send_word(make_word(32767, -32768, 0, -32768, 32767, 0));
        send_word(make_word(1, 0, 0, 0, 0, 0));
        send_word(make_word(-1, -1, -1, 0, 0, 0));
        send_word(make_word(1, 1, 1, 1, 1, 1));
        send_word(make_word(0, 0, 1, 32767, 0, 0));
        send_word(make_word(-32768, 0, 0, 0, 0, 0));
        send_word(make_word(0, 32767, 0, 0, -32768, 0));
        send_word(make_word(12345, -23456, 31000, -2048, 1024, 512));
    endtask

    // send forty words, hold off until every result is back, then send forty more
    task automatic test_drain_pause();
        for (int n = 0; n < 40; n++)
            send_word(make_word($urandom, $urandom, $urandom, 2048, 0, 0));
        wait_drained();
        for (int n = 0; n < 40; n++)
            send_word(make_word(rand_comp(), rand_comp(), rand_comp(),
                                rand_comp(), rand_comp(), rand_comp()));
    endtask

    // random words with extreme, zero, small and full range components, some using the incident as normal
    task automatic test_random();
        in_word_t w;
        for (int n = 0; n < 2000; n++)
        begin
            if (n == 1000)
                stall_enable = 1'b0;
            if (n == 1300)
                stall_enable = 1'b1;
            w = make_word(rand_comp(), rand_comp(), rand_comp(),
                          rand_comp(), rand_comp(), rand_comp());
            if ($urandom_range(0, 9) == 0)
                w = make_word(w.inc_x, w.inc_y, w.inc_z, w.inc_x, w.inc_y, w.inc_z);
            send_word(w);
        end
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (!stall_enable)
            result_ready <= 1'b1;
        else
            result_ready <= (cycle_count % 23 < 17) ? ($urandom_range(0, 3) != 0) : 1'b0;
    end

    // result checking
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_refl.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
            end
            else
            begin
                want = expected_refl.pop_front();
                if (result.refl_x !== want.refl_x)
                    report_mismatch("refl_x", result.refl_x, want.refl_x);
                if (result.refl_y !== want.refl_y)
                    report_mismatch("refl_y", result.refl_y, want.refl_y);
                if (result.refl_z !== want.refl_z)
                    report_mismatch("refl_z", result.refl_z, want.refl_z);
                if (result.zero_length !== want.zero_length)
                    report_mismatch("zero_length", result.zero_length, want.zero_length);
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        mismatches   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        stall_enable = 1'b1;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_random();
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_refl.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
src/vrn_pkg.sv
src/vrn_front.sv
src/vrn_fifo.sv
src/vrn_sqrt.sv
src/vrn_div.sv
src/vector_reflect_normalize_core.sv
src/vrn_checker.sv
bench/tb_vector_reflect_normalize_core.sv
